// ----- design/pgn_pkg.sv -----
// Shared types and codes for the 3-D gradient noise core.
`default_nettype none
package pgn_pkg;

    // command codes on the input item
    localparam logic [1:0] CMD_LOAD_GRAD = 2'd0;
    localparam logic [1:0] CMD_LOAD_PERM = 2'd1;
    localparam logic [1:0] CMD_NOISE     = 2'd2;
    localparam logic [1:0] CMD_TURB      = 2'd3;

    // permutation table selectors
    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;

    localparam int OUT_W = 19;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_GRAD,
        KIND_PERM,
        KIND_EVAL
    } pgn_kind_t;

    // classified item handed from the front queue to the engine
    typedef struct packed {
        pgn_kind_t    kind;
        logic         turb;
        logic [1:0]   sel;
        logic [7:0]   idx;
        logic [7:0]   pval;
        logic [15:0]  gx;
        logic [15:0]  gy;
        logic [15:0]  gz;
        logic [31:0]  px;
        logic [31:0]  py;
        logic [31:0]  pz;
        logic [3:0]   octaves;
    } pgn_item_t;

endpackage
`default_nettype wire

// ----- design/pgn_front.sv -----
// Front end: takes input items, classifies them and queues them for the engine.
`default_nettype none
module pgn_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [167:0]       s_tdata,
    input  wire logic [3:0]         s_tuser,
    output logic                    q_valid,
    output pgn_pkg::pgn_item_t      q_item,
    input  wire logic               q_pop
);
    import pgn_pkg::*;

    pgn_item_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    pgn_item_t  in_item;
    logic       push, pop;

    always_comb begin
        in_item.sel     = s_tuser[3:2];
        in_item.idx     = s_tdata[7:0];
        in_item.pval    = s_tdata[15:8];
        in_item.gx      = s_tdata[31:16];
        in_item.gy      = s_tdata[47:32];
        in_item.gz      = s_tdata[63:48];
        in_item.px      = s_tdata[95:64];
        in_item.py      = s_tdata[127:96];
        in_item.pz      = s_tdata[159:128];
        in_item.octaves = s_tdata[163:160];
        in_item.turb    = (s_tuser[1:0] == CMD_TURB);
        case (s_tuser[1:0])
            CMD_LOAD_GRAD: in_item.kind = KIND_GRAD;
            CMD_LOAD_PERM: in_item.kind = (s_tuser[3:2] inside {SEL_X, SEL_Y, SEL_Z}) ?
                                          KIND_PERM : KIND_NOP;
            default:       in_item.kind = KIND_EVAL;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ----- design/pgn_engine.sv -----
// Back end: table memories, sequenced noise datapath and result register.
`default_nettype none
module pgn_engine #(
    parameter int TABLE_SIZE  = 256,
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire pgn_pkg::pgn_item_t q_item,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata
);
    import pgn_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int TB   = $clog2(TABLE_SIZE);
    localparam int PW   = F + TB;
    localparam int DW   = F + 5;
    localparam int SW   = F + 20;
    localparam int AW   = F + 8;
    localparam int BW   = F + 3;
    localparam int PRW  = AW + BW;
    localparam int ACW  = DW + MAX_OCTAVES;
    localparam int VW   = ACW + 1;
    localparam int SR   = (F >= 16) ? F - 16 : 0;
    localparam int SL   = (F < 16) ? 16 - F : 0;
    localparam int OW   = VW + SL;
    localparam int OCW  = $clog2(MAX_OCTAVES + 1);
    localparam logic [F+1:0] ONE_U   = (F+2)'(1) << F;
    localparam logic [F+1:0] THREE_U = (F+2)'(3) << F;
    localparam logic signed [OW-1:0] SAT_HI = OW'(262143);
    localparam logic signed [OW-1:0] SAT_LO = -OW'(262144);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PERM, ST_GADDR, ST_GX, ST_GY, ST_GZ, ST_GEND,
        ST_SQ, ST_SM1, ST_SM2, ST_BL, ST_BLEND, ST_ACC, ST_FIN
    } state_t;

    // table memories, no reset
    logic [7:0]  perm_x_mem [TABLE_SIZE];
    logic [7:0]  perm_y_mem [TABLE_SIZE];
    logic [7:0]  perm_z_mem [TABLE_SIZE];
    logic [47:0] grad_mem   [TABLE_SIZE];
    logic [7:0]  px0_reg, px1_reg, py0_reg, py1_reg, pz0_reg, pz1_reg;
    logic [47:0] grad_reg;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic [PW-1:0] ptx_reg, ptx_next, pty_reg, pty_next, ptz_reg, ptz_next;
    logic          turb_reg, turb_next;
    logic [OCW-1:0] n_reg, n_next, oct_reg, oct_next;
    logic [2:0]    k_reg, k_next, bn_reg, bn_next;
    logic [1:0]    ax_reg, ax_next;
    logic signed [AW-1:0] mul_a_reg, mul_a_next;
    logic signed [BW-1:0] mul_b_reg, mul_b_next;
    logic signed [PRW-1:0] prod;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [DW-1:0] line_reg [8];
    logic signed [DW-1:0] line_next [8];
    logic [F:0]    sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    logic signed [DW-1:0] noise_reg, noise_next;
    logic signed [ACW-1:0] acc_reg, acc_next;

    logic [TB-1:0] cx, cy, cz, ld_idx, hash;
    logic [F-1:0]  fx, fy, fz, f_ax;
    logic signed [F+1:0] dx, dy, dz;
    logic [F:0]    t_sel;
    logic signed [SW-1:0] sum_full;
    logic signed [DW:0]   diff;
    logic signed [DW-1:0] blend_res;
    logic [ACW-1:0] mag;
    logic signed [VW-1:0] final_v;
    logic signed [OW-1:0] scaled;
    logic [4:0]    oct_in;
    logic [OCW:0]  oct_inc;
    logic [OCW-1:0] shamt;

    assign cx = ptx_reg[PW-1:F];
    assign cy = pty_reg[PW-1:F];
    assign cz = ptz_reg[PW-1:F];
    assign fx = ptx_reg[F-1:0];
    assign fy = pty_reg[F-1:0];
    assign fz = ptz_reg[F-1:0];
    assign ld_idx = TB'(q_item.idx);
    assign hash = TB'((k_reg[2] ? px1_reg : px0_reg) ^ (k_reg[1] ? py1_reg : py0_reg) ^
                      (k_reg[0] ? pz1_reg : pz0_reg));
    // corner offsets: d = f - corner
    assign dx = $signed({2'b00, fx}) - $signed(k_reg[2] ? ONE_U : '0);
    assign dy = $signed({2'b00, fy}) - $signed(k_reg[1] ? ONE_U : '0);
    assign dz = $signed({2'b00, fz}) - $signed(k_reg[0] ? ONE_U : '0);
    assign prod = mul_a_reg * mul_b_reg;
    assign sum_full = sum_reg + SW'(prod);
    assign diff = {line_reg[1][DW-1], line_reg[1]} - {line_reg[0][DW-1], line_reg[0]};
    assign blend_res = line_reg[0] + DW'(prod >>> F);
    assign oct_inc = {1'b0, oct_reg} + 1'b1;
    assign shamt = OCW'(MAX_OCTAVES - 1) - oct_reg;
    assign oct_in = {1'b0, q_item.octaves};

    always_comb begin
        case (ax_reg)
            2'd0:    f_ax = fx;
            2'd1:    f_ax = fy;
            default: f_ax = fz;
        endcase
        // z weight for the first four blends, then y, then x
        if (bn_reg < 3'd4) begin
            t_sel = sz_reg;
        end else if (bn_reg < 3'd6) begin
            t_sel = sy_reg;
        end else begin
            t_sel = sx_reg;
        end
    end

    // final scaling to Q2.16 with saturation
    always_comb begin
        mag = acc_reg[ACW-1] ? ACW'(-acc_reg) : ACW'(acc_reg);
        if (turb_reg) begin
            final_v = $signed({1'b0, mag >> (MAX_OCTAVES - 1)});
        end else begin
            final_v = VW'(noise_reg);
        end
        scaled = (OW'(final_v) >>> SR) <<< SL;
        if (scaled > SAT_HI) begin
            out_next = OUT_W'(SAT_HI);
        end else if (scaled < SAT_LO) begin
            out_next = OUT_W'(SAT_LO);
        end else begin
            out_next = OUT_W'(scaled);
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ptx_next = ptx_reg;  pty_next = pty_reg;  ptz_next = ptz_reg;
        turb_next = turb_reg;
        n_next = n_reg;  oct_next = oct_reg;
        k_next = k_reg;  bn_next = bn_reg;  ax_next = ax_reg;
        mul_a_next = mul_a_reg;  mul_b_next = mul_b_reg;
        sum_next = sum_reg;
        sx_next = sx_reg;  sy_next = sy_reg;  sz_next = sz_reg;
        noise_next = noise_reg;  acc_next = acc_reg;
        line_next = line_reg;
        q_pop = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.kind == KIND_EVAL) begin
                        ptx_next  = PW'($signed(q_item.px));
                        pty_next  = PW'($signed(q_item.py));
                        ptz_next  = PW'($signed(q_item.pz));
                        turb_next = q_item.turb;
                        acc_next  = '0;
                        oct_next  = '0;
                        if (!q_item.turb) begin
                            n_next = OCW'(1);
                        end else if (oct_in > 5'(MAX_OCTAVES)) begin
                            n_next = OCW'(MAX_OCTAVES);
                        end else begin
                            n_next = OCW'(q_item.octaves);
                        end
                        state_next = (q_item.turb && q_item.octaves == 4'd0) ? ST_FIN : ST_PERM;
                    end
                end
            end
            ST_PERM: begin
                k_next     = '0;
                state_next = ST_GADDR;
            end
            ST_GADDR: begin
                state_next = ST_GX;
            end
            ST_GX: begin
                mul_a_next = AW'($signed(grad_reg[15:0]));
                mul_b_next = BW'(dx);
                state_next = ST_GY;
            end
            ST_GY: begin
                sum_next   = SW'(prod);
                mul_a_next = AW'($signed(grad_reg[31:16]));
                mul_b_next = BW'(dy);
                state_next = ST_GZ;
            end
            ST_GZ: begin
                sum_next   = sum_full;
                mul_a_next = AW'($signed(grad_reg[47:32]));
                mul_b_next = BW'(dz);
                state_next = ST_GEND;
            end
            ST_GEND: begin
                line_next[k_reg] = DW'(sum_full >>> 14);
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7) begin
                    ax_next    = '0;
                    state_next = ST_SQ;
                end else begin
                    state_next = ST_GADDR;
                end
            end
            ST_SQ: begin
                mul_a_next = AW'($signed({1'b0, f_ax}));
                mul_b_next = BW'($signed({1'b0, f_ax}));
                state_next = ST_SM1;
            end
            ST_SM1: begin
                mul_a_next = AW'($signed({1'b0, prod[2*F-1:F]}));
                mul_b_next = BW'($signed({1'b0, THREE_U - {f_ax, 1'b0}}));
                state_next = ST_SM2;
            end
            ST_SM2: begin
                case (ax_reg)
                    2'd0:    sx_next = prod[2*F:F];
                    2'd1:    sy_next = prod[2*F:F];
                    default: sz_next = prod[2*F:F];
                endcase
                ax_next = ax_reg + 2'd1;
                if (ax_reg == 2'd2) begin
                    bn_next    = '0;
                    state_next = ST_BL;
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_BL: begin
                mul_a_next = AW'(diff);
                mul_b_next = BW'($signed({1'b0, t_sel}));
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                // pop the two head entries, append the blend behind the survivors
                for (int i = 0; i < 6; i++) begin
                    line_next[i] = line_reg[i+2];
                end
                line_next[3'd6 - bn_reg] = blend_res;
                bn_next = bn_reg + 3'd1;
                if (bn_reg == 3'd6) begin
                    noise_next = blend_res;
                    state_next = ST_ACC;
                end else begin
                    state_next = ST_BL;
                end
            end
            ST_ACC: begin
                acc_next = acc_reg + (ACW'(noise_reg) <<< shamt);
                ptx_next = ptx_reg << 1;
                pty_next = pty_reg << 1;
                ptz_next = ptz_reg << 1;
                oct_next = oct_inc[OCW-1:0];
                state_next = (oct_inc < {1'b0, n_reg}) ? ST_PERM : ST_FIN;
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == ST_FIN && state_next == ST_IDLE) begin
                out_reg <= out_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptx_reg <= ptx_next;  pty_reg <= pty_next;  ptz_reg <= ptz_next;
        turb_reg <= turb_next;
        n_reg <= n_next;  oct_reg <= oct_next;
        k_reg <= k_next;  bn_reg <= bn_next;  ax_reg <= ax_next;
        mul_a_reg <= mul_a_next;  mul_b_reg <= mul_b_next;
        sum_reg <= sum_next;
        sx_reg <= sx_next;  sy_reg <= sy_next;  sz_reg <= sz_next;
        noise_reg <= noise_next;  acc_reg <= acc_next;
        line_reg <= line_next;
    end

    // memories: one write port, registered reads
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            if (q_item.kind == KIND_GRAD) begin
                grad_mem[ld_idx] <= {q_item.gz, q_item.gy, q_item.gx};
            end
            if (q_item.kind == KIND_PERM && q_item.sel == SEL_X) begin
                perm_x_mem[ld_idx] <= q_item.pval;
            end
            if (q_item.kind == KIND_PERM && q_item.sel == SEL_Y) begin
                perm_y_mem[ld_idx] <= q_item.pval;
            end
            if (q_item.kind == KIND_PERM && q_item.sel == SEL_Z) begin
                perm_z_mem[ld_idx] <= q_item.pval;
            end
        end
        if (state_reg == ST_PERM) begin
            px0_reg <= perm_x_mem[cx];
            px1_reg <= perm_x_mem[cx + 1'b1];
            py0_reg <= perm_y_mem[cy];
            py1_reg <= perm_y_mem[cy + 1'b1];
            pz0_reg <= perm_z_mem[cz];
            pz1_reg <= perm_z_mem[cz + 1'b1];
        end
        if (state_reg == ST_GADDR) begin
            grad_reg <= grad_mem[hash];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_reg};

endmodule
`default_nettype wire

// ----- design/perlin_gradient_noise_3d_core.sv -----
// Top level of the 3-D gradient noise and turbulence core.
// Steps: a table load is written by the engine straight from the queue; noise runs per
// octave a perm read, 8 corners x 5 steps of gradient read and shared multiplier,
// 3 smoothsteps x 3 steps, 7 blends x 2 steps and an accumulate, then a final step;
// turbulence with zero octaves goes straight to the final step. One item is worked at a
// time; a 2-item queue takes input meanwhile and registers each item before the engine.
// Reset (aresetn low, synchronous) clears queue, sequencer and output valid; the tables
// are not cleared.
`default_nettype none
module perlin_gradient_noise_3d_core #(
    parameter int TABLE_SIZE  = 256,
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: table_index, perm_value, grad_x, grad_y, grad_z, point_x, point_y,
    // point_z, octaves (from bit 0 up), zero padded
    input  wire logic [167:0] s_tdata,
    // tuser: command, table_select (from bit 0 up)
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: noise_value (bits 18:0), zero padded
    output logic [23:0]       m_tdata
);
    import pgn_pkg::*;

    logic      q_valid;
    logic      q_pop;
    pgn_item_t q_item;

    // front: classify and queue
    pgn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: tables, sequenced datapath, result register
    pgn_engine #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_OCTAVES (MAX_OCTAVES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
